// ----- hw/rtl/stt_pkg.sv -----
// shared types, token codes and lookup functions for the source text tokenizer
package stt_pkg;

  // input item: one source byte or an end-of-text mark
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // result item: one token character or one token end
  typedef struct packed {
    logic [7:0] text_char;
    logic       char_valid;
    logic       token_done;
    logic [4:0] token_kind;
    logic [2:0] error_code;
    logic       last;
  } out_t;

  // result queue depth, holds at least one worst-case byte plus slack
  localparam int FIFO_DEPTH = 8;
  // most results a single byte can produce
  localparam int MAX_RESULTS = 3;

  // token kinds
  localparam logic [4:0] KIND_ID       = 5'd0;
  localparam logic [4:0] KIND_ASSIGN   = 5'd1;
  localparam logic [4:0] KIND_EQ       = 5'd2;
  localparam logic [4:0] KIND_NE       = 5'd3;
  localparam logic [4:0] KIND_LT       = 5'd4;
  localparam logic [4:0] KIND_LE       = 5'd5;
  localparam logic [4:0] KIND_GT       = 5'd6;
  localparam logic [4:0] KIND_GE       = 5'd7;
  localparam logic [4:0] KIND_OR       = 5'd8;
  localparam logic [4:0] KIND_AND      = 5'd9;
  localparam logic [4:0] KIND_SEMI     = 5'd10;
  localparam logic [4:0] KIND_LPAREN   = 5'd11;
  localparam logic [4:0] KIND_RPAREN   = 5'd12;
  localparam logic [4:0] KIND_LBRACE   = 5'd13;
  localparam logic [4:0] KIND_RBRACE   = 5'd14;
  localparam logic [4:0] KIND_COMMA    = 5'd15;
  localparam logic [4:0] KIND_PLUS     = 5'd16;
  localparam logic [4:0] KIND_MINUS    = 5'd17;
  localparam logic [4:0] KIND_STAR     = 5'd18;
  localparam logic [4:0] KIND_SLASH    = 5'd19;
  localparam logic [4:0] KIND_STRING   = 5'd20;
  localparam logic [4:0] KIND_NUMBER   = 5'd21;
  localparam logic [4:0] KIND_CHAR     = 5'd22;
  localparam logic [4:0] KIND_TRUE     = 5'd23;
  localparam logic [4:0] KIND_FALSE    = 5'd24;
  localparam logic [4:0] KIND_IF       = 5'd25;
  localparam logic [4:0] KIND_ELSEIF   = 5'd26;
  localparam logic [4:0] KIND_ELSE     = 5'd27;
  localparam logic [4:0] KIND_WHILE    = 5'd28;
  localparam logic [4:0] KIND_RETURN   = 5'd29;
  localparam logic [4:0] KIND_EOF      = 5'd30;
  localparam logic [4:0] KIND_ERROR    = 5'd31;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_SECOND_DOT   = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR_LIT = 3'd2;
  localparam logic [2:0] ERR_UNEXPECTED   = 3'd3;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

  // characters with a role in the scanner
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] CH_PIPE    = 8'h7c;

  // keyword texts, oldest character in the high byte
  localparam logic [47:0] KW_TRUE   = 48'h0000_7472_7565;
  localparam logic [47:0] KW_FALSE  = 48'h0066_616c_7365;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_ELSEIF = 48'h656c_7365_6966;
  localparam logic [47:0] KW_ELSE   = 48'h0000_656c_7365;
  localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6c65;
  localparam logic [47:0] KW_AND    = 48'h0000_0061_6e64;
  localparam logic [47:0] KW_OR     = 48'h0000_0000_6f72;
  localparam logic [47:0] KW_NOT    = 48'h0000_006e_6f74;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726e;

  // kind of a one-byte punctuation or arithmetic token, KIND_ID when none
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h3b:   k = KIND_SEMI;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7b:   k = KIND_LBRACE;
      8'h7d:   k = KIND_RBRACE;
      8'h2c:   k = KIND_COMMA;
      8'h2b:   k = KIND_PLUS;
      8'h2d:   k = KIND_MINUS;
      8'h2a:   k = KIND_STAR;
      8'h2f:   k = KIND_SLASH;
      default: k = KIND_ID;
    endcase
    return k;
  endfunction

  // keyword match on the stored identifier prefix and its length
  function automatic logic [4:0] keyword_kind(input logic [47:0] prefix,
                                              input logic [2:0] len);
    logic [4:0] k;
    k = KIND_ID;
    priority if (len == 3'd4 && prefix == KW_TRUE)   k = KIND_TRUE;
    else if     (len == 3'd5 && prefix == KW_FALSE)  k = KIND_FALSE;
    else if     (len == 3'd2 && prefix == KW_IF)     k = KIND_IF;
    else if     (len == 3'd6 && prefix == KW_ELSEIF) k = KIND_ELSEIF;
    else if     (len == 3'd4 && prefix == KW_ELSE)   k = KIND_ELSE;
    else if     (len == 3'd5 && prefix == KW_WHILE)  k = KIND_WHILE;
    else if     (len == 3'd3 && prefix == KW_AND)    k = KIND_AND;
    else if     (len == 3'd2 && prefix == KW_OR)     k = KIND_OR;
    else if     (len == 3'd3 && prefix == KW_NOT)    k = KIND_NE;
    else if     (len == 3'd6 && prefix == KW_RETURN) k = KIND_RETURN;
    else                                             k = KIND_ID;
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

// ----- hw/rtl/source_text_tokenizer_top.sv -----
// byte-serial tokenizer: scanner state, per-byte result logic and result queue
//
//   channel   dir   handshake            payload
//   src       in    src_valid/src_ready  stt_pkg::in_t  (text_byte, end_of_text)
//   tok       out   tok_valid/tok_ready  stt_pkg::out_t (one token char or token end)
//
// one byte is taken per cycle while src_ready is high; its zero to three results are
// written to the result queue at the transfer edge and leave it one per cycle while
// tok_ready is high. src_ready is high while the queue has room for three results,
// so a byte that yields two or three results, or a stalled tok side, holds the source
// back. synchronous reset leaves the scanner idle and the queue empty.
module source_text_tokenizer_top #(
  parameter int FifoDepth = stt_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_ready,
  input  stt_pkg::in_t  src_data,
  output logic          tok_valid,
  input  logic          tok_ready,
  output stt_pkg::out_t tok_data
);

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam int MaxR = stt_pkg::MAX_RESULTS;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_COMMENT,
    MODE_CHAR_BODY,
    MODE_CHAR_CLOSE
  } mode_t;

  // scanner state
  mode_t       scan_mode, scan_mode_next;
  logic [7:0]  pending_operator, pending_operator_next;
  logic        dot_seen, dot_seen_next;
  logic [47:0] word_prefix, word_prefix_next;
  logic [2:0]  word_length, word_length_next;

  // result queue
  stt_pkg::out_t        mem [FifoDepth];
  logic [PtrW-1:0]      rd_ptr, wr_ptr, rd_ptr_next, wr_ptr_next;
  logic [CntW-1:0]      count, count_next;
  logic [PtrW-1:0]      wr_idx [MaxR];

  // per-byte results
  stt_pkg::out_t res_list [MaxR];
  logic [1:0]    res_n;
  logic          rescan;
  logic [7:0]    c;
  logic          eof;
  logic          push, pop;

  function automatic stt_pkg::out_t mk_char(input logic [7:0] ch);
    stt_pkg::out_t r;
    r            = '0;
    r.text_char  = ch;
    r.char_valid = 1'b1;
    return r;
  endfunction

  function automatic stt_pkg::out_t mk_done(input logic [4:0] kind);
    stt_pkg::out_t r;
    r            = '0;
    r.token_done = 1'b1;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic stt_pkg::out_t mk_err(input logic [2:0] code);
    stt_pkg::out_t r;
    r            = '0;
    r.token_done = 1'b1;
    r.token_kind = stt_pkg::KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  assign push      = src_valid && src_ready;
  assign pop       = tok_valid && tok_ready;
  assign src_ready = (count <= CntW'(FifoDepth - MaxR));
  assign tok_valid = (count != '0);
  assign tok_data  = mem[rd_ptr];

  assign c   = src_data.text_byte;
  assign eof = src_data.end_of_text || (c == stt_pkg::CH_NUL);

  // scan one byte: mode handling, then a fresh idle scan where the token ended
  always_comb begin
    scan_mode_next        = scan_mode;
    pending_operator_next = pending_operator;
    dot_seen_next         = dot_seen;
    word_prefix_next      = word_prefix;
    word_length_next      = word_length;
    res_list              = '{default: '0};
    res_n                 = 2'd0;
    rescan                = 1'b0;

    unique case (scan_mode)
      MODE_IDLE: begin
        rescan = 1'b1;
      end
      MODE_OP: begin
        if (!eof && ((c == stt_pkg::CH_EQ &&
                      (pending_operator == stt_pkg::CH_EQ ||
                       pending_operator == stt_pkg::CH_BANG ||
                       pending_operator == stt_pkg::CH_LT ||
                       pending_operator == stt_pkg::CH_GT)) ||
                     (c == pending_operator &&
                      (pending_operator == stt_pkg::CH_PIPE ||
                       pending_operator == stt_pkg::CH_AMP)))) begin
          res_list[res_n] = mk_char(c);
          res_n = res_n + 2'd1;
          priority case (pending_operator)
            stt_pkg::CH_EQ:   res_list[res_n] = mk_done(stt_pkg::KIND_EQ);
            stt_pkg::CH_BANG: res_list[res_n] = mk_done(stt_pkg::KIND_NE);
            stt_pkg::CH_LT:   res_list[res_n] = mk_done(stt_pkg::KIND_LE);
            stt_pkg::CH_GT:   res_list[res_n] = mk_done(stt_pkg::KIND_GE);
            stt_pkg::CH_PIPE: res_list[res_n] = mk_done(stt_pkg::KIND_OR);
            default:          res_list[res_n] = mk_done(stt_pkg::KIND_AND);
          endcase
          res_n = res_n + 2'd1;
          scan_mode_next        = MODE_IDLE;
          pending_operator_next = '0;
        end else begin
          // single operator closes; lone bang, pipe or ampersand is an error
          priority case (pending_operator)
            stt_pkg::CH_EQ: res_list[res_n] = mk_done(stt_pkg::KIND_ASSIGN);
            stt_pkg::CH_LT: res_list[res_n] = mk_done(stt_pkg::KIND_LT);
            stt_pkg::CH_GT: res_list[res_n] = mk_done(stt_pkg::KIND_GT);
            default:        res_list[res_n] = mk_err(stt_pkg::ERR_UNEXPECTED);
          endcase
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!eof && (stt_pkg::is_letter(c) || stt_pkg::is_digit(c))) begin
          res_list[res_n] = mk_char(c);
          res_n = res_n + 2'd1;
          if (word_length < 3'd6) begin
            word_prefix_next = {word_prefix[39:0], c};
            word_length_next = word_length + 3'd1;
          end else begin
            word_length_next = 3'd7;
          end
        end else begin
          res_list[res_n] = mk_done(stt_pkg::keyword_kind(word_prefix, word_length));
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!eof && stt_pkg::is_digit(c)) begin
          res_list[res_n] = mk_char(c);
          res_n = res_n + 2'd1;
        end else if (!eof && c == stt_pkg::CH_DOT) begin
          res_list[res_n] = mk_char(c);
          res_n = res_n + 2'd1;
          if (dot_seen) begin
            res_list[res_n] = mk_err(stt_pkg::ERR_SECOND_DOT);
            res_n = res_n + 2'd1;
            scan_mode_next = MODE_IDLE;
            dot_seen_next  = 1'b0;
          end else begin
            dot_seen_next = 1'b1;
          end
        end else begin
          res_list[res_n] = mk_done(stt_pkg::KIND_NUMBER);
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end
      end
      MODE_STRING: begin
        if (eof) begin
          res_list[res_n] = mk_err(stt_pkg::ERR_UNTERMINATED);
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end else if (c == stt_pkg::CH_DQUOTE) begin
          res_list[res_n] = mk_done(stt_pkg::KIND_STRING);
          res_n = res_n + 2'd1;
          scan_mode_next = MODE_IDLE;
        end else begin
          res_list[res_n] = mk_char(c);
          res_n = res_n + 2'd1;
        end
      end
      MODE_COMMENT: begin
        if (eof) begin
          rescan = 1'b1;
        end else if (c == stt_pkg::CH_LF) begin
          scan_mode_next = MODE_IDLE;
        end
      end
      MODE_CHAR_BODY: begin
        if (eof) begin
          res_list[res_n] = mk_err(stt_pkg::ERR_UNTERMINATED);
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end else begin
          res_list[res_n] = mk_char(c);
          res_n = res_n + 2'd1;
          scan_mode_next = MODE_CHAR_CLOSE;
        end
      end
      MODE_CHAR_CLOSE: begin
        if (eof) begin
          res_list[res_n] = mk_err(stt_pkg::ERR_UNTERMINATED);
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end else if (c == stt_pkg::CH_SQUOTE) begin
          res_list[res_n] = mk_done(stt_pkg::KIND_CHAR);
          res_n = res_n + 2'd1;
          scan_mode_next = MODE_IDLE;
        end else begin
          res_list[res_n] = mk_err(stt_pkg::ERR_BAD_CHAR_LIT);
          res_n  = res_n + 2'd1;
          rescan = 1'b1;
        end
      end
    endcase

    // token ended: start from idle and scan this byte again
    if (rescan) begin
      scan_mode_next        = MODE_IDLE;
      pending_operator_next = '0;
      dot_seen_next         = 1'b0;
      word_prefix_next      = '0;
      word_length_next      = '0;
      if (eof) begin
        res_list[res_n] = mk_done(stt_pkg::KIND_EOF);
        res_n = res_n + 2'd1;
      end else if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_LF) begin
        scan_mode_next = MODE_IDLE;
      end else if (c == stt_pkg::CH_HASH) begin
        scan_mode_next = MODE_COMMENT;
      end else if (c == stt_pkg::CH_DQUOTE) begin
        scan_mode_next = MODE_STRING;
      end else if (c == stt_pkg::CH_SQUOTE) begin
        scan_mode_next = MODE_CHAR_BODY;
      end else if (stt_pkg::is_digit(c)) begin
        res_list[res_n] = mk_char(c);
        res_n = res_n + 2'd1;
        scan_mode_next = MODE_NUMBER;
      end else if (c == stt_pkg::CH_EQ || c == stt_pkg::CH_BANG ||
                   c == stt_pkg::CH_LT || c == stt_pkg::CH_GT ||
                   c == stt_pkg::CH_PIPE || c == stt_pkg::CH_AMP) begin
        res_list[res_n] = mk_char(c);
        res_n = res_n + 2'd1;
        scan_mode_next        = MODE_OP;
        pending_operator_next = c;
      end else if (stt_pkg::punct_kind(c) != stt_pkg::KIND_ID) begin
        res_list[res_n] = mk_char(c);
        res_n = res_n + 2'd1;
        res_list[res_n] = mk_done(stt_pkg::punct_kind(c));
        res_n = res_n + 2'd1;
      end else if (stt_pkg::is_letter(c)) begin
        res_list[res_n] = mk_char(c);
        res_n = res_n + 2'd1;
        scan_mode_next   = MODE_IDENT;
        word_prefix_next = {40'd0, c};
        word_length_next = 3'd1;
      end else begin
        // stray byte
        res_list[res_n] = mk_char(c);
        res_n = res_n + 2'd1;
        res_list[res_n] = mk_err(stt_pkg::ERR_UNEXPECTED);
        res_n = res_n + 2'd1;
      end
    end

    // mark the final result of this byte
    if (res_n != 2'd0) begin
      res_list[res_n - 2'd1].last = 1'b1;
    end
  end

  // queue slots for this byte's results, wrapping at the depth
  always_comb begin
    logic [PtrW:0] sum;
    for (int i = 0; i < MaxR; i++) begin
      sum = {1'b0, wr_ptr} + (PtrW + 1)'(i);
      if (sum >= (PtrW + 1)'(FifoDepth)) begin
        sum = sum - (PtrW + 1)'(FifoDepth);
      end
      wr_idx[i] = sum[PtrW-1:0];
    end
  end

  // queue pointers and fill count
  always_comb begin
    logic [PtrW:0] wsum;
    logic [PtrW:0] rsum;
    wsum = {1'b0, wr_ptr} + (PtrW + 1)'(push ? res_n : 2'd0);
    if (wsum >= (PtrW + 1)'(FifoDepth)) begin
      wsum = wsum - (PtrW + 1)'(FifoDepth);
    end
    wr_ptr_next = wsum[PtrW-1:0];
    rsum = {1'b0, rd_ptr} + (PtrW + 1)'(pop);
    if (rsum >= (PtrW + 1)'(FifoDepth)) begin
      rsum = rsum - (PtrW + 1)'(FifoDepth);
    end
    rd_ptr_next = rsum[PtrW-1:0];
    count_next  = count + CntW'(push ? res_n : 2'd0) - CntW'(pop);
  end

  // scanner state and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode        <= MODE_IDLE;
      pending_operator <= '0;
      dot_seen         <= 1'b0;
      word_prefix      <= '0;
      word_length      <= '0;
      rd_ptr           <= '0;
      wr_ptr           <= '0;
      count            <= '0;
    end else begin
      if (push) begin
        scan_mode        <= scan_mode_next;
        pending_operator <= pending_operator_next;
        dot_seen         <= dot_seen_next;
        word_prefix      <= word_prefix_next;
        word_length      <= word_length_next;
      end
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxR; i++) begin
      if (push && (2'(i) < res_n)) begin
        mem[wr_idx[i]] <= res_list[i];
      end
    end
  end

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  // a drain with nothing added lowers the count by one
  a_count_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !(push && res_n != 2'd0)) |=> count == $past(count) - CntW'(1))
    else $error("result queue count off after drain");

  // end of text leaves the scanner idle and cleared
  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    (push && eof) |=> (scan_mode == MODE_IDLE && word_length == 3'd0 &&
                       dot_seen == 1'b0 && pending_operator == 8'd0))
    else $error("scanner not idle after end of text");

  // every queued result is either a character or a token end
  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_data.char_valid ^ tok_data.token_done))
    else $error("malformed result at queue head");

  // identifier length only held while scanning an identifier
  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    (word_length != 3'd0) |-> (scan_mode == MODE_IDENT))
    else $error("identifier length outside identifier mode");

endmodule
